>>> design/i2cbb_pkg.sv
// Shared types and constants for the I2C bit-bang pin sequencer.
// No dependencies; used by the interfaces, i2cbb_seq and the top level.
`default_nettype none

package i2cbb_pkg;

  // Operation codes carried in the kind field
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_STOP  = 2'd1;

  // Pin bits: bit 0 SCL, bit 1 SDA
  localparam logic [1:0] PIN_LOW  = 2'b00;
  localparam logic [1:0] PIN_SCL  = 2'b01;
  localparam logic [1:0] PIN_SDA  = 2'b10;
  localparam logic [1:0] PIN_BOTH = 2'b11;

  // Upper six bits of the PIO byte are always set
  localparam logic [5:0] PIO_HIGH = 6'h3F;

  localparam int unsigned KindW = 2;
  localparam int unsigned WordW = 9;
  localparam int unsigned PinW  = 2;
  localparam int unsigned PioW  = 8;

  // Bit slot index of the ack bit (data bits are slots 0..7)
  localparam logic [3:0] ACK_SLOT = 4'd8;
  // Phase codes within one bit slot
  localparam logic [1:0] PH_SETUP = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;
  // Final step index of start and stop
  localparam logic [1:0] START_END = 2'd3;
  localparam logic [1:0] STOP_END  = 2'd1;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_START,
    SEQ_STOP,
    SEQ_BYTE
  } seq_state_e;

  // One pin step offered by the sequencer
  typedef struct packed {
    logic            valid;
    logic [PinW-1:0] pin_state;
    logic            last;
  } seq_step_t;

  // Start: SCL high, both high (forced stop), SCL high, both low
  function automatic logic [PinW-1:0] start_pins(input logic [1:0] step);
    logic [PinW-1:0] p;
    unique case (step)
      2'd0:    p = PIN_SCL;
      2'd1:    p = PIN_BOTH;
      2'd2:    p = PIN_SCL;
      default: p = PIN_LOW;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> design/i2cbb_if.sv
// Handshake channels of the I2C bit-bang pin sequencer: request in, pin step out.
// Depends on i2cbb_pkg for field widths.
`default_nettype none

interface i2cbb_req_if;
  logic                           valid;
  logic                           ready;
  logic [i2cbb_pkg::KindW-1:0]    kind;
  logic [i2cbb_pkg::WordW-1:0]    data_word;

  modport source (output valid, output kind, output data_word, input ready);
  modport sink   (input valid, input kind, input data_word, output ready);
endinterface

interface i2cbb_pin_if;
  logic                           valid;
  logic                           ready;
  logic [i2cbb_pkg::PinW-1:0]     pin_state;
  logic [i2cbb_pkg::PioW-1:0]     pio_byte;
  logic                           last;

  modport source (output valid, output pin_state, output pio_byte, output last, input ready);
  modport sink   (input valid, input pin_state, input pio_byte, input last, output ready);
endinterface

`default_nettype wire

>>> design/i2c_bitbang_pin_sequencer_unit.sv
// Top level of the I2C bit-bang pin sequencer: config register, sequencer and
// registered pin step output. Depends on i2cbb_pkg, i2cbb_if.sv and i2cbb_seq.
//
//   channel  dir  handshake     payload
//   req_i    in   valid/ready   kind, data_word
//   pin_o    out  valid/ready   pin_state, pio_byte, last
//   cfg      in   cfg_we_i      cfg_wdata_i (release_sda_after_bit)
//
// One pin step per cycle unless the output stalls. Start issues 4 steps, stop 2,
// a byte 27, set by the three-phase bit slot counter and nine-bit shift register.
// The next request is taken in the cycle the last step of the current one issues.
// Reset clears the sequencer, the output valid and the config bit.
// A stalled output holds its step and the sequencer waits behind it.
`default_nettype none

module i2c_bitbang_pin_sequencer_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_wdata_i,
  i2cbb_req_if.sink          req_i,
  i2cbb_pin_if.source        pin_o
);

  logic                          release_q;
  logic                          out_valid_q, out_valid_d;
  logic [i2cbb_pkg::PinW-1:0]    pin_q;
  logic                          last_q;
  logic                          adv;
  logic                          step_fire;
  logic                          req_fire;
  i2cbb_pkg::seq_step_t          step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      release_q <= 1'b0;
    end else if (cfg_we_i) begin
      release_q <= cfg_wdata_i;
    end
  end

  assign adv       = !out_valid_q || pin_o.ready;
  assign step_fire = step.valid && adv;
  assign req_i.ready = !step.valid || (step_fire && step.last);
  assign req_fire  = req_i.valid && req_i.ready;

  i2cbb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (req_fire),
    .kind_i      (req_i.kind),
    .data_word_i (req_i.data_word),
    .release_i   (release_q),
    .adv_i       (adv),
    .step_o      (step)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (step_fire) begin
      out_valid_d = 1'b1;
    end else if (pin_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      pin_q  <= step.pin_state;
      last_q <= step.last;
    end
  end

  assign pin_o.valid     = out_valid_q;
  assign pin_o.pin_state = pin_q;
  assign pin_o.pio_byte  = {i2cbb_pkg::PIO_HIGH, pin_q};
  assign pin_o.last      = last_q;

  // a request never lands on top of an operation still issuing steps
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |-> (!step.valid || (step_fire && step.last)))
    else $error("request accepted while an operation is in progress");

  // an accepted request always starts issuing steps next cycle
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> step.valid)
    else $error("sequencer idle after request accepted");

  // after the final step the sequencer is idle unless a new request was taken
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && step.last && !req_fire) |=> !step.valid)
    else $error("sequencer kept running after final step");

  // a stalled output is never overwritten by a new step
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pin_o.ready) |-> !step_fire)
    else $error("step issued into a stalled output register");

endmodule

`default_nettype wire

>>> design/i2cbb_seq.sv
// Pin step sequencer: sends data bits MSB first, then ack, one bit slot of three
// phases at a time, and walks the fixed start and stop patterns. Uses i2cbb_pkg.
`default_nettype none

module i2cbb_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  wire logic [i2cbb_pkg::KindW-1:0]   kind_i,
  input  wire logic [i2cbb_pkg::WordW-1:0]   data_word_i,
  input  wire logic                          release_i,
  input  wire logic                          adv_i,
  output i2cbb_pkg::seq_step_t               step_o
);

  i2cbb_pkg::seq_state_e            state_q, state_d;
  logic [1:0]                       phase_q, phase_d;
  logic [3:0]                       slot_q, slot_d;
  logic [i2cbb_pkg::WordW-1:0]      shift_q, shift_d;
  logic                             sda;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2cbb_pkg::SEQ_IDLE;
      phase_q <= 2'd0;
      slot_q  <= 4'd0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      slot_q  <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  assign sda = shift_q[i2cbb_pkg::WordW-1];

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    slot_d  = slot_q;
    shift_d = shift_q;
    step_o  = '{valid: 1'b0, pin_state: i2cbb_pkg::PIN_LOW, last: 1'b0};

    unique case (state_q)
      i2cbb_pkg::SEQ_IDLE: begin
        step_o.valid = 1'b0;
      end
      i2cbb_pkg::SEQ_START: begin
        step_o.valid     = 1'b1;
        step_o.pin_state = i2cbb_pkg::start_pins(phase_q);
        step_o.last      = (phase_q == i2cbb_pkg::START_END);
      end
      i2cbb_pkg::SEQ_STOP: begin
        step_o.valid     = 1'b1;
        step_o.pin_state = (phase_q == i2cbb_pkg::STOP_END) ? i2cbb_pkg::PIN_BOTH
                                                            : i2cbb_pkg::PIN_SCL;
        step_o.last      = (phase_q == i2cbb_pkg::STOP_END);
      end
      i2cbb_pkg::SEQ_BYTE: begin
        step_o.valid = 1'b1;
        unique case (phase_q)
          i2cbb_pkg::PH_SETUP: step_o.pin_state = {sda, 1'b0};
          i2cbb_pkg::PH_HIGH:  step_o.pin_state = {sda, 1'b1};
          default: begin
            // ack slot always holds its level
            step_o.pin_state = (release_i && slot_q != i2cbb_pkg::ACK_SLOT)
                               ? i2cbb_pkg::PIN_SDA : {sda, 1'b0};
          end
        endcase
        step_o.last = (slot_q == i2cbb_pkg::ACK_SLOT) && (phase_q == i2cbb_pkg::PH_LOW);
      end
      default: step_o.valid = 1'b0;
    endcase

    if (step_o.valid && adv_i) begin
      if (step_o.last) begin
        state_d = i2cbb_pkg::SEQ_IDLE;
      end else if (state_q == i2cbb_pkg::SEQ_BYTE && phase_q == i2cbb_pkg::PH_LOW) begin
        phase_d = i2cbb_pkg::PH_SETUP;
        slot_d  = slot_q + 4'd1;
        shift_d = {shift_q[i2cbb_pkg::WordW-2:0], 1'b0};
      end else begin
        phase_d = phase_q + 2'd1;
      end
    end

    // a new request may load while the last step of the previous one issues
    if (load_i) begin
      phase_d = 2'd0;
      slot_d  = 4'd0;
      // ack bit rotated to the bottom so it goes out after the eight data bits
      shift_d = {data_word_i[i2cbb_pkg::WordW-2:0], data_word_i[i2cbb_pkg::WordW-1]};
      if (kind_i == i2cbb_pkg::KIND_START) begin
        state_d = i2cbb_pkg::SEQ_START;
      end else if (kind_i == i2cbb_pkg::KIND_STOP) begin
        state_d = i2cbb_pkg::SEQ_STOP;
      end else begin
        state_d = i2cbb_pkg::SEQ_BYTE;
      end
    end
  end

endmodule

`default_nettype wire
